// ===== rtl/core/alt_pkg.sv =====
`default_nettype none

package alt_pkg;

    // Number formatting: magnitudes saturate at 2^(VALUE_BITS-1)-1.
    localparam int VALUE_BITS = 32;
    localparam int TOKEN_W    = 32;
    localparam int MAG_W      = VALUE_BITS - 1;
    localparam int SUM_W      = MAG_W + 4;

    // Depth of the result queue and its occupancy width.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = FIFO_AW + 1;

    // Character codes that the lexer recognises.
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    // Input command codes.
    localparam logic CMD_CHAR = 1'b0;
    localparam logic CMD_EOI  = 1'b1;

    // Error codes.
    localparam logic ERR_MINUS  = 1'b0;
    localparam logic ERR_DOLLAR = 1'b1;

    // Lexer modes.
    typedef enum logic [2:0] {
        M_IDLE   = 3'd0,
        M_POS    = 3'd1,
        M_NEG    = 3'd2,
        M_REG    = 3'd3,
        M_OPC    = 3'd4,
        M_MINUS  = 3'd5,
        M_DOLLAR = 3'd6,
        M_SKIP   = 3'd7
    } t_lex_mode;

    // Token kinds.
    typedef enum logic [2:0] {
        K_END   = 3'd0,
        K_SEP   = 3'd1,
        K_INT   = 3'd2,
        K_REG   = 3'd3,
        K_OPC   = 3'd4,
        K_OPEND = 3'd5,
        K_ERR   = 3'd6
    } t_kind;

    // One result item.
    typedef struct packed {
        t_kind              kind;
        logic [TOKEN_W-1:0] value;
        logic [7:0]         op_char;
        logic               err;
        logic               sat;
        logic               last;
    } t_token;

    // Results produced by the lexer for one input item.
    typedef struct packed {
        logic   emit0;
        logic   emit1;
        t_token tok0;
        t_token tok1;
    } t_lex_out;

    // Result queue status seen by the top level.
    typedef struct packed {
        logic [FIFO_CW-1:0] count;
        logic               room;
    } t_fifo_status;

    // Builds a token with all unused fields cleared.
    function automatic t_token mk_tok(t_kind kind, logic [TOKEN_W-1:0] value,
                                      logic [7:0] ch, logic err, logic sat);
        t_token t;
        t.kind    = kind;
        t.value   = value;
        t.op_char = ch;
        t.err     = err;
        t.sat     = sat;
        t.last    = 1'b0;
        return t;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/alt_lexer.sv =====
`default_nettype none

module alt_lexer
    import alt_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_go,
    input  wire logic       i_cmd,
    input  wire logic [7:0] i_char_code,
    output t_lex_out        o_res
);

    t_lex_mode        r_mode, n_mode;
    logic [MAG_W-1:0] r_acc, n_acc;
    logic             r_ovf, n_ovf;

    logic             is_ws;
    logic             is_dig;
    logic [3:0]       digit;
    logic [SUM_W-1:0] acc_sum;
    logic             acc_sat;
    t_token           num_tok;
    logic [TOKEN_W-1:0] num_val;
    logic             ib_emit;
    t_token           ib_tok;
    t_lex_mode        ib_mode;

    // Character classes and the multiply-by-ten accumulate.
    always_comb begin
        is_ws   = (i_char_code == CH_SPACE) ||
                  ((i_char_code >= CH_TAB) && (i_char_code <= CH_CR));
        is_dig  = (i_char_code >= CH_ZERO) && (i_char_code <= CH_NINE);
        digit   = 4'(i_char_code - CH_ZERO);
        acc_sum = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1) + SUM_W'(digit);
        acc_sat = acc_sum > SUM_W'({MAG_W{1'b1}});
    end

    // The number token that a flush would send.
    always_comb begin
        num_val = TOKEN_W'({1'b0, r_acc});
        if (r_mode == M_NEG) begin
            num_val = TOKEN_W'(0) - num_val;
        end
        num_tok = mk_tok((r_mode == M_REG) ? K_REG : K_INT, num_val, 8'h00, 1'b0, r_ovf);
    end

    // Handling of a byte seen between tokens.
    always_comb begin
        ib_emit = 1'b0;
        ib_tok  = mk_tok(K_END, '0, 8'h00, 1'b0, 1'b0);
        ib_mode = M_IDLE;
        if (is_ws) begin
            ib_mode = M_IDLE;
        end else if (i_char_code == CH_SEMI) begin
            ib_emit = 1'b1;
            ib_mode = M_SKIP;
        end else if (i_char_code == CH_COMMA) begin
            ib_emit = 1'b1;
            ib_tok  = mk_tok(K_SEP, '0, 8'h00, 1'b0, 1'b0);
        end else if (is_dig) begin
            ib_mode = M_POS;
        end else if (i_char_code == CH_MINUS) begin
            ib_mode = M_MINUS;
        end else if (i_char_code == CH_DOLLAR) begin
            ib_mode = M_DOLLAR;
        end else begin
            ib_emit = 1'b1;
            ib_tok  = mk_tok(K_OPC, '0, i_char_code, 1'b0, 1'b0);
            ib_mode = M_OPC;
        end
    end

    // Next state and results for the item being processed.
    always_comb begin
        n_mode = r_mode;
        n_acc  = r_acc;
        n_ovf  = r_ovf;
        o_res.emit0 = 1'b0;
        o_res.emit1 = 1'b0;
        o_res.tok0  = mk_tok(K_END, '0, 8'h00, 1'b0, 1'b0);
        o_res.tok1  = mk_tok(K_END, '0, 8'h00, 1'b0, 1'b0);
        if (i_go) begin
            if (i_cmd == CMD_EOI) begin
                unique case (r_mode)
                    M_IDLE: begin
                        o_res.emit0 = 1'b1;
                    end
                    M_POS, M_NEG, M_REG: begin
                        o_res.emit0 = 1'b1;
                        o_res.tok0  = num_tok;
                        o_res.emit1 = 1'b1;
                    end
                    M_OPC: begin
                        o_res.emit0 = 1'b1;
                        o_res.tok0  = mk_tok(K_OPEND, '0, 8'h00, 1'b0, 1'b0);
                        o_res.emit1 = 1'b1;
                    end
                    M_MINUS: begin
                        o_res.emit0 = 1'b1;
                        o_res.tok0  = mk_tok(K_ERR, '0, 8'h00, ERR_MINUS, 1'b0);
                    end
                    M_DOLLAR: begin
                        o_res.emit0 = 1'b1;
                        o_res.tok0  = mk_tok(K_ERR, '0, 8'h00, ERR_DOLLAR, 1'b0);
                    end
                    default: begin
                    end
                endcase
                n_mode = M_IDLE;
                n_acc  = '0;
                n_ovf  = 1'b0;
            end else begin
                unique case (r_mode)
                    M_IDLE: begin
                        o_res.emit0 = ib_emit;
                        o_res.tok0  = ib_tok;
                        n_mode      = ib_mode;
                        if (is_dig) begin
                            n_acc = MAG_W'(digit);
                            n_ovf = 1'b0;
                        end
                    end
                    M_POS, M_NEG, M_REG: begin
                        if (is_dig) begin
                            n_acc = acc_sat ? {MAG_W{1'b1}} : acc_sum[MAG_W-1:0];
                            n_ovf = r_ovf | acc_sat;
                        end else begin
                            // Flush the number, then treat the byte as between tokens.
                            o_res.emit0 = 1'b1;
                            o_res.tok0  = num_tok;
                            o_res.emit1 = ib_emit;
                            o_res.tok1  = ib_tok;
                            n_mode      = ib_mode;
                            n_acc       = '0;
                            n_ovf       = 1'b0;
                        end
                    end
                    M_OPC: begin
                        o_res.emit0 = 1'b1;
                        if (is_ws) begin
                            o_res.tok0 = mk_tok(K_OPEND, '0, 8'h00, 1'b0, 1'b0);
                            n_mode     = M_IDLE;
                        end else begin
                            o_res.tok0 = mk_tok(K_OPC, '0, i_char_code, 1'b0, 1'b0);
                        end
                    end
                    M_MINUS, M_DOLLAR: begin
                        if (is_dig) begin
                            n_acc  = MAG_W'(digit);
                            n_ovf  = 1'b0;
                            n_mode = (r_mode == M_MINUS) ? M_NEG : M_REG;
                        end else begin
                            o_res.emit0 = 1'b1;
                            o_res.tok0  = mk_tok(K_ERR, '0, 8'h00,
                                                 (r_mode == M_DOLLAR) ? ERR_DOLLAR : ERR_MINUS,
                                                 1'b0);
                            n_mode      = M_SKIP;
                        end
                    end
                    default: begin
                        n_mode = M_SKIP;
                    end
                endcase
            end
        end
        // The last result of the item carries the run-last mark.
        o_res.tok0.last = !o_res.emit1;
        o_res.tok1.last = 1'b1;
    end

    // Lexer state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_acc  <= '0;
            r_ovf  <= 1'b0;
        end else begin
            r_mode <= n_mode;
            r_acc  <= n_acc;
            r_ovf  <= n_ovf;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/alt_token_fifo.sv =====
`default_nettype none

module alt_token_fifo
    import alt_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_lex_out i_res,
    input  wire logic   i_rd,
    output t_token      o_head,
    output logic        o_valid,
    output t_fifo_status o_status
);

    t_token             r_q [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wp, n_wp;
    logic [FIFO_AW-1:0] r_rp, n_rp;
    logic [FIFO_CW-1:0] r_count, n_count;
    logic [FIFO_CW-1:0] wr_n;
    logic               rd_do;

    // Pointer and occupancy updates.
    always_comb begin
        rd_do   = i_rd && (r_count != '0);
        wr_n    = FIFO_CW'(i_res.emit0) + FIFO_CW'(i_res.emit1);
        n_wp    = r_wp + FIFO_AW'(wr_n);
        n_rp    = r_rp + FIFO_AW'(rd_do);
        n_count = r_count + wr_n - FIFO_CW'(rd_do);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    // Up to two entries are written per cycle, in order.
    always_ff @(posedge i_clk) begin
        if (i_res.emit0) begin
            r_q[r_wp] <= i_res.tok0;
        end
        if (i_res.emit1) begin
            r_q[r_wp + FIFO_AW'(1)] <= i_res.tok1;
        end
    end

    // The head entry drives the output; room means at least two free entries.
    always_comb begin
        o_head         = r_q[r_rp];
        o_valid        = (r_count != '0);
        o_status.count = r_count;
        o_status.room  = (r_count <= FIFO_CW'(FIFO_DEPTH - 2));
    end

endmodule

`default_nettype wire

// ===== rtl/core/assembly_line_tokenizer_core.sv =====
//  Channel   Direction  Handshake            Payload
//  input     in         i_valid / o_stall    i_cmd, i_char_code
//  result    out        o_valid / i_stall    o_token_kind, o_token_value, o_op_char,
//                                            o_error_code, o_value_saturated, o_run_last
//
//  An item is registered on acceptance and is lexed when the queue has room; it then writes its
//  zero, one or two results into a four-entry result queue, and the first result can leave
//  in the cycle after it is written. One item is accepted per cycle while o_stall is low; an
//  item that yields two results needs two output transfers, so the output port sets the
//  long-run rate. Lexing waits while the queue has fewer than two free entries, and the input
//  stalls only while the registered item is waiting. Reset is synchronous and clears the lexer
//  state, the input stage and the queue.
`default_nettype none

module assembly_line_tokenizer_core
    import alt_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_stall,
    input  wire logic                      i_cmd,
    input  wire logic [7:0]                i_char_code,
    output logic                           o_valid,
    input  wire logic                      i_stall,
    output logic [2:0]                     o_token_kind,
    output logic signed [TOKEN_W-1:0]      o_token_value,
    output logic [7:0]                     o_op_char,
    output logic                           o_error_code,
    output logic                           o_value_saturated,
    output logic                           o_run_last
);

    logic         r_in_vld, n_in_vld;
    logic         r_in_cmd;
    logic [7:0]   r_in_char;
    logic         in_acc;
    logic         lex_go;
    t_lex_out     lex_res;
    t_token       head;
    t_fifo_status fifo_st;

    // Input stage control.
    always_comb begin
        lex_go   = r_in_vld && fifo_st.room;
        o_stall  = r_in_vld && !lex_go;
        in_acc   = i_valid && !o_stall;
        n_in_vld = in_acc || (r_in_vld && !lex_go);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= n_in_vld;
        end
    end

    // The input payload is loaded only when an item is taken.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_cmd  <= i_cmd;
            r_in_char <= i_char_code;
        end
    end

    alt_lexer u_lexer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (lex_go),
        .i_cmd       (r_in_cmd),
        .i_char_code (r_in_char),
        .o_res       (lex_res)
    );

    alt_token_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_res    (lex_res),
        .i_rd     (!i_stall),
        .o_head   (head),
        .o_valid  (o_valid),
        .o_status (fifo_st)
    );

    // Result fields from the head of the queue.
    always_comb begin
        o_token_kind      = head.kind;
        o_token_value     = head.value;
        o_op_char         = head.op_char;
        o_error_code      = head.err;
        o_value_saturated = head.sat;
        o_run_last        = head.last;
    end

`ifndef SYNTH
    // The queue never holds more entries than it has.
    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_st.count <= FIFO_CW'(FIFO_DEPTH))
        else $error("result queue overfilled");

    // A registered item that is not lexed stays in place unchanged.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !lex_go) |=> (r_in_vld && $stable(r_in_char) && $stable(r_in_cmd)))
        else $error("waiting item lost or changed");

    // A second result is only ever written together with a first one.
    a_emit_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lex_res.emit1 |-> (lex_res.emit0 && lex_go))
        else $error("second result without first");

    // Occupancy follows writes and reads.
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (lex_go && !lex_res.emit0 && !(o_valid && !i_stall)) |=>
        $stable(fifo_st.count))
        else $error("queue count changed without traffic");
`endif

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`default_nettype none

module testbench;
    import alt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TARGET_ITEMS   = 1900;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int HOLD_CYCLES    = 120;
    localparam int HOLD_EVERY     = 600;
    localparam longint unsigned MAG_MAX = (64'd1 << MAG_W) - 1;

    // One input item waiting to be sent; drain asks the sender to wait for an empty pipe.
    typedef struct {
        logic       cmd;
        logic [7:0] ch;
        bit         drain;
    } t_in_byte;

    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     i_valid     = 1'b0;
    logic                     i_cmd       = CMD_CHAR;
    logic [7:0]               i_char_code = 8'h00;
    logic                     i_stall     = 1'b0;
    logic                     o_stall;
    logic                     o_valid;
    logic [2:0]               o_token_kind;
    logic signed [TOKEN_W-1:0] o_token_value;
    logic [7:0]               o_op_char;
    logic                     o_error_code;
    logic                     o_value_saturated;
    logic                     o_run_last;

    t_in_byte  pending_bytes[$];
    t_token    expected_tokens[$];
    t_token    step_tokens[$];

    // Lexer state as the predictor sees it.
    t_lex_mode         lx_mode = M_IDLE;
    longint unsigned   lx_mag  = 0;
    bit                lx_ovf  = 1'b0;

    int  failures      = 0;
    int  counted_items = 0;
    bit  drain_flag    = 1'b0;
    bit  send_calm     = 1'b0;
    bit  recv_calm     = 1'b0;
    int  send_gap      = 0;
    int  stall_left    = 0;
    int  hold_left     = 0;
    int  holds_done    = 0;
    int  results_taken = 0;
    int  idle_cycles   = 0;

    assembly_line_tokenizer_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_cmd            (i_cmd),
        .i_char_code      (i_char_code),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_token_kind     (o_token_kind),
        .o_token_value    (o_token_value),
        .o_op_char        (o_op_char),
        .o_error_code     (o_error_code),
        .o_value_saturated(o_value_saturated),
        .o_run_last       (o_run_last)
    );

    always #10 i_clk = ~i_clk;

    // Character classes.
    function automatic bit is_space(logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic t_token token_of(t_kind k, logic [TOKEN_W-1:0] v, logic [7:0] ch,
                                        logic e, logic s);
        t_token t;
        t.kind    = k;
        t.value   = v;
        t.op_char = ch;
        t.err     = e;
        t.sat     = s;
        t.last    = 1'b0;
        return t;
    endfunction

    // Appends a token to those caused by the item being predicted.
    function automatic void add_step_token(t_token t);
        step_tokens.insert(step_tokens.size(), t);
    endfunction

    // Sends the pending number or register and returns to idle.
    function automatic void flush_number();
        logic [TOKEN_W-1:0] v;
        v = lx_mag[TOKEN_W-1:0];
        if (lx_mode == M_NEG)
            v = -v;
        add_step_token(token_of((lx_mode == M_REG) ? K_REG : K_INT, v, 8'h00, 1'b0,
                                lx_ovf));
        lx_mag  = 0;
        lx_ovf  = 1'b0;
        lx_mode = M_IDLE;
    endfunction

    // Handles a byte that arrives between tokens.
    function automatic void lex_between(logic [7:0] c);
        if (is_space(c)) begin
            return;
        end
        if (c == CH_SEMI) begin
            add_step_token(token_of(K_END, '0, 8'h00, 1'b0, 1'b0));
            lx_mode = M_SKIP;
        end else if (c == CH_COMMA) begin
            add_step_token(token_of(K_SEP, '0, 8'h00, 1'b0, 1'b0));
        end else if (is_digit(c)) begin
            lx_mag  = 64'(c - CH_ZERO);
            lx_ovf  = 1'b0;
            lx_mode = M_POS;
        end else if (c == CH_MINUS) begin
            lx_mode = M_MINUS;
        end else if (c == CH_DOLLAR) begin
            lx_mode = M_DOLLAR;
        end else begin
            add_step_token(token_of(K_OPC, '0, c, 1'b0, 1'b0));
            lx_mode = M_OPC;
        end
    endfunction

    // Works out the tokens that one accepted item causes and queues them.
    function automatic void predict_tokens(logic cmd, logic [7:0] c);
        longint unsigned d;
        step_tokens.delete();
        if (cmd == CMD_EOI) begin
            case (lx_mode)
                M_IDLE: begin
                    add_step_token(token_of(K_END, '0, 8'h00, 1'b0, 1'b0));
                end
                M_POS, M_NEG, M_REG: begin
                    flush_number();
                    add_step_token(token_of(K_END, '0, 8'h00, 1'b0, 1'b0));
                end
                M_OPC: begin
                    add_step_token(token_of(K_OPEND, '0, 8'h00, 1'b0, 1'b0));
                    add_step_token(token_of(K_END, '0, 8'h00, 1'b0, 1'b0));
                end
                M_MINUS: begin
                    add_step_token(token_of(K_ERR, '0, 8'h00, ERR_MINUS, 1'b0));
                end
                M_DOLLAR: begin
                    add_step_token(token_of(K_ERR, '0, 8'h00, ERR_DOLLAR, 1'b0));
                end
                default: ;
            endcase
            lx_mode = M_IDLE;
            lx_mag  = 0;
            lx_ovf  = 1'b0;
        end else begin
            case (lx_mode)
                M_IDLE: begin
                    lex_between(c);
                end
                M_POS, M_NEG, M_REG: begin
                    if (is_digit(c)) begin
                        d = 64'(c - CH_ZERO);
                        if (lx_mag > (MAG_MAX - d) / 10) begin
                            lx_mag = MAG_MAX;
                            lx_ovf = 1'b1;
                        end else begin
                            lx_mag = lx_mag * 10 + d;
                        end
                    end else begin
                        flush_number();
                        lex_between(c);
                    end
                end
                M_OPC: begin
                    if (is_space(c)) begin
                        add_step_token(token_of(K_OPEND, '0, 8'h00, 1'b0, 1'b0));
                        lx_mode = M_IDLE;
                    end else begin
                        add_step_token(token_of(K_OPC, '0, c, 1'b0, 1'b0));
                    end
                end
                M_MINUS, M_DOLLAR: begin
                    if (is_digit(c)) begin
                        lx_mag  = 64'(c - CH_ZERO);
                        lx_ovf  = 1'b0;
                        lx_mode = (lx_mode == M_MINUS) ? M_NEG : M_REG;
                    end else begin
                        add_step_token(token_of(K_ERR, '0, 8'h00,
                            (lx_mode == M_MINUS) ? ERR_MINUS : ERR_DOLLAR, 1'b0));
                        lx_mode = M_SKIP;
                    end
                end
                default: begin
                    lx_mode = M_SKIP;
                end
            endcase
        end
        if (step_tokens.size() > 0)
            step_tokens[step_tokens.size() - 1].last = 1'b1;
        foreach (step_tokens[i])
            expected_tokens.insert(expected_tokens.size(), step_tokens[i]);
    endfunction

    // Idle length: mostly none or short, now and then long, none at all in calm stretches.
    function automatic int pick_gap(bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] pick_space();
        int r;
        r = $urandom_range(0, 6);
        return (r < 5) ? 8'(CH_TAB + r) : CH_SPACE;
    endfunction

    // A byte that cannot start or continue a number.
    function automatic logic [7:0] pick_non_digit();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(0, 255));
        end while (is_digit(c));
        return c;
    endfunction

    task automatic push_byte(logic cmd, logic [7:0] ch, bit counts);
        t_in_byte b;
        b.cmd   = cmd;
        b.ch    = ch;
        b.drain = drain_flag;
        drain_flag = 1'b0;
        pending_bytes.insert(pending_bytes.size(), b);
        if (counts)
            counted_items++;
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(CMD_CHAR, s[i], 1'b1);
    endtask

    task automatic push_digits(int n);
        for (int i = 0; i < n; i++)
            push_byte(CMD_CHAR, 8'(CH_ZERO + $urandom_range(0, 9)), 1'b1);
    endtask

    // Random number body: mostly short, sometimes long enough to saturate or on the limit.
    task automatic push_number();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            push_text("2147483647");
        else if (r == 1)
            push_text("2147483648");
        else if (r < 4)
            push_digits($urandom_range(9, 12));
        else
            push_digits($urandom_range(1, 4));
    endtask

    // Stimulus: directed lines first, then random lines of mostly well-formed tokens.
    initial begin
        int         line_no;
        int         ntok;
        int         len;
        logic [7:0] c;

        // Opcode made of a null byte and a letter with a semicolon inside it, then
        // vertical tab to close it, and the top character code on an end of input.
        push_byte(CMD_CHAR, 8'h00, 1'b1);
        push_text("a;");
        push_byte(CMD_CHAR, 8'h0B, 1'b1);
        push_byte(CMD_EOI, 8'hFF, 1'b1);
        // Negative number ended by a comma, then a dollar sign cut short by end of input.
        push_text("-7,$");
        push_byte(CMD_EOI, 8'h00, 1'b1);
        // Register ended by a minus that lacks its digit, shown by a non-digit byte.
        push_text("$3-");
        push_byte(CMD_CHAR, 8'hFF, 1'b1);
        push_byte(CMD_EOI, 8'h5A, 1'b1);
        // Saturating number ended by a semicolon.
        push_text("9999999999;");
        push_byte(CMD_EOI, 8'h3B, 1'b1);

        line_no = 0;
        while (counted_items < TARGET_ITEMS) begin
            line_no++;
            if (line_no == 20 || line_no == 90 || line_no == 250)
                drain_flag = 1'b1;
            ntok = $urandom_range(1, 6);
            for (int t = 0; t < ntok; t++) begin
                len = $urandom_range(0, 2);
                for (int w = 0; w < len; w++)
                    push_byte(CMD_CHAR, pick_space(), 1'b1);
                case ($urandom_range(0, 11))
                    0, 1, 2: begin
                        // Opcode: usually a letter first, then any non-space bytes.
                        if ($urandom_range(0, 9) < 7) begin
                            c = 8'("a" + $urandom_range(0, 25));
                        end else begin
                            do begin
                                c = 8'($urandom_range(0, 255));
                            end while (is_space(c) || is_digit(c) || c == CH_SEMI ||
                                       c == CH_COMMA || c == CH_MINUS || c == CH_DOLLAR);
                        end
                        push_byte(CMD_CHAR, c, 1'b1);
                        len = $urandom_range(0, 4);
                        for (int k = 0; k < len; k++) begin
                            if ($urandom_range(0, 9) < 6) begin
                                c = 8'("a" + $urandom_range(0, 25));
                            end else begin
                                do begin
                                    c = 8'($urandom_range(0, 255));
                                end while (is_space(c));
                            end
                            push_byte(CMD_CHAR, c, 1'b1);
                        end
                    end
                    3, 4: begin
                        if ($urandom_range(0, 2) == 0)
                            push_byte(CMD_CHAR, CH_MINUS, 1'b1);
                        push_number();
                    end
                    5, 6: begin
                        push_byte(CMD_CHAR, CH_DOLLAR, 1'b1);
                        push_number();
                    end
                    7: begin
                        push_byte(CMD_CHAR, CH_COMMA, 1'b1);
                    end
                    8: begin
                        // Minus or dollar without a digit, including a signed register.
                        case ($urandom_range(0, 2))
                            0: push_byte(CMD_CHAR, CH_MINUS, 1'b1);
                            1: push_byte(CMD_CHAR, CH_DOLLAR, 1'b1);
                            default: push_text("-$");
                        endcase
                        if ($urandom_range(0, 3) != 0)
                            push_byte(CMD_CHAR, pick_non_digit(), 1'b1);
                    end
                    default: begin
                        push_byte(CMD_CHAR, 8'($urandom_range(0, 255)), 1'b1);
                    end
                endcase
                case ($urandom_range(0, 3))
                    0: push_byte(CMD_CHAR, CH_COMMA, 1'b1);
                    1, 2: push_byte(CMD_CHAR, pick_space(), 1'b1);
                    default: ;
                endcase
            end
            // Line end: plain end of input, or a semicolon followed by ignored bytes.
            if ($urandom_range(0, 9) < 3) begin
                push_byte(CMD_CHAR, CH_SEMI, 1'b1);
                len = $urandom_range(0, 3);
                for (int k = 0; k < len; k++)
                    push_byte(CMD_CHAR, 8'($urandom_range(0, 255)), 1'b0);
            end
            push_byte(CMD_EOI, 8'($urandom_range(0, 255)), 1'b1);
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every item to be taken and every token to come back.
        while (pending_bytes.size() > 0 || i_valid || expected_tokens.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (failures == 0)
            $display("assembly_line_tokenizer_core regression: pass");
        else
            $display("assembly_line_tokenizer_core regression: fail");
        $finish;
    end

    // Sender: predicts each accepted item and offers the next one after a random gap.
    always @(posedge i_clk) begin
        bit       took;
        t_in_byte nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            took = i_valid && !o_stall;
            if (took)
                predict_tokens(i_cmd, i_char_code);
            if ($urandom_range(0, 299) == 0)
                send_calm = !send_calm;
            if (!i_valid || took) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (pending_bytes.size() > 0 &&
                             !(pending_bytes[0].drain && expected_tokens.size() > 0)) begin
                    nxt = pending_bytes.pop_front();
                    i_cmd       <= nxt.cmd;
                    i_char_code <= nxt.ch;
                    i_valid     <= 1'b1;
                    send_gap = pick_gap(send_calm);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver back-pressure: random stalls plus an occasional long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall)
                results_taken++;
            if ($urandom_range(0, 299) == 0)
                recv_calm = !recv_calm;
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (holds_done < 2 && results_taken >= (holds_done + 1) * HOLD_EVERY) begin
                holds_done++;
                hold_left = HOLD_CYCLES - 1;
                i_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else begin
                stall_left = pick_gap(recv_calm);
                i_stall <= (stall_left > 0);
                if (stall_left > 0)
                    stall_left--;
            end
        end
    end

    // Token checker: each accepted token against the oldest expected one.
    always @(posedge i_clk) begin
        t_token want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_tokens.size() == 0) begin
                $error("unexpected token: token_kind %0d, token_value %0d",
                       o_token_kind, o_token_value);
                failures++;
            end else begin
                want = expected_tokens.pop_front();
                if (o_token_kind !== want.kind) begin
                    $error("token_kind: expected %0d, got %0d", want.kind, o_token_kind);
                    failures++;
                end
                if (o_token_value !== want.value) begin
                    $error("token_value: expected %0d, got %0d",
                           $signed(want.value), o_token_value);
                    failures++;
                end
                if (o_op_char !== want.op_char) begin
                    $error("op_char: expected %0d, got %0d", want.op_char, o_op_char);
                    failures++;
                end
                if (o_error_code !== want.err) begin
                    $error("error_code: expected %0d, got %0d", want.err, o_error_code);
                    failures++;
                end
                if (o_value_saturated !== want.sat) begin
                    $error("value_saturated: expected %0d, got %0d", want.sat,
                           o_value_saturated);
                    failures++;
                end
                if (o_run_last !== want.last) begin
                    $error("run_last: expected %0d, got %0d", want.last, o_run_last);
                    failures++;
                end
            end
        end
    end

    // Watchdog: ends the run when neither channel moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles == WATCHDOG_LIMIT) begin
                $display("assembly_line_tokenizer_core regression: fail");
                $finish;
            end
        end
    end

endmodule

`default_nettype wire
